/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers: same-cycle and next-cycle implications on clk / arst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/owrs_pkg.sv */
// ---------------------------------------------------------------------------
// owrs_pkg
// shared types and constants of the one-wire rom search engine
// ---------------------------------------------------------------------------
package owrs_pkg;

	localparam int ROM_BITS_DEF = 64;
	localparam int FAMILY_LIMIT = 9;
	localparam int FD_W         = 4;
	localparam int CMD_W        = 8;
	localparam int ROM_OUT_W    = 64;

	typedef enum logic [2:0] {
		OP_START  = 3'd0,
		OP_PAIR   = 3'd1,
		OP_RESET  = 3'd2,
		OP_SKIP   = 3'd3,
		OP_TARGET = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_CMD  = 2'd1,
		ACT_DIR  = 2'd2
	} action_t;

	typedef struct packed {
		logic             complement_bit;
		logic             id_bit;
		logic [CMD_W-1:0] command;
		logic             no_presence;
		op_t              op;
	} item_t;

	typedef struct packed {
		action_t          action;
		logic [CMD_W-1:0] command_out;
		logic             direction;
		logic             pass_done;
		logic             found;
	} result_t;

endpackage

/* rtl/owrs_step.sv */
// ---------------------------------------------------------------------------
// owrs_step
// next search state and result for one item, purely combinational
// ---------------------------------------------------------------------------
module owrs_step #(
	parameter int ROM_BITS = owrs_pkg::ROM_BITS_DEF
) (
	input  owrs_pkg::item_t                   item,
	input  logic [owrs_pkg::CMD_W-1:0]        target_family,
	input  logic [ROM_BITS-1:0]               rom,
	input  logic [$clog2(ROM_BITS+2)-1:0]     last_disc,
	input  logic [owrs_pkg::FD_W-1:0]         fam_disc,
	input  logic                              last_dev,
	input  logic [$clog2(ROM_BITS+2)-1:0]     bit_num,
	input  logic [$clog2(ROM_BITS+2)-1:0]     zero_pos,
	input  logic                              pass_act,
	output logic [ROM_BITS-1:0]               rom_nx,
	output logic [$clog2(ROM_BITS+2)-1:0]     last_disc_nx,
	output logic [owrs_pkg::FD_W-1:0]         fam_disc_nx,
	output logic                              last_dev_nx,
	output logic [$clog2(ROM_BITS+2)-1:0]     bit_num_nx,
	output logic [$clog2(ROM_BITS+2)-1:0]     zero_pos_nx,
	output logic                              pass_act_nx,
	output owrs_pkg::result_t                 res
);

	localparam int POS_W = $clog2(ROM_BITS+2);
	localparam int IDX_W = $clog2(ROM_BITS);

	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] pos_m1;
	logic [IDX_W-1:0] idx;
	logic             dir;
	logic             ambiguous;
	logic [POS_W-1:0] lz_pair;
	logic [owrs_pkg::FD_W-1:0] fd_pair;
	logic [ROM_BITS-1:0] rom_pair;

	// bit pair datapath
	always_comb begin
		pos = bit_num;
		if (bit_num < POS_W'(1) || bit_num > POS_W'(ROM_BITS)) begin
			pos = POS_W'(1);
		end
		pos_m1    = pos - POS_W'(1);
		idx       = pos_m1[IDX_W-1:0];
		ambiguous = (item.id_bit == item.complement_bit);
		if (!ambiguous) begin
			dir = item.id_bit;
		end else if (pos < last_disc) begin
			dir = rom[idx];
		end else begin
			dir = (pos == last_disc);
		end
		lz_pair = zero_pos;
		fd_pair = fam_disc;
		if (ambiguous && !dir) begin
			lz_pair = pos;
			if (pos < POS_W'(owrs_pkg::FAMILY_LIMIT)) begin
				fd_pair = pos[owrs_pkg::FD_W-1:0];
			end
		end
		rom_pair      = rom;
		rom_pair[idx] = dir;
	end

	always_comb begin
		rom_nx       = rom;
		last_disc_nx = last_disc;
		fam_disc_nx  = fam_disc;
		last_dev_nx  = last_dev;
		bit_num_nx   = bit_num;
		zero_pos_nx  = zero_pos;
		pass_act_nx  = pass_act;
		res          = '{action: owrs_pkg::ACT_NONE, command_out: '0, direction: 1'b0,
			pass_done: 1'b0, found: 1'b0};
		unique case (item.op)
			owrs_pkg::OP_START: begin
				if (last_dev || item.no_presence) begin
					last_disc_nx  = '0;
					fam_disc_nx   = '0;
					last_dev_nx   = 1'b0;
					pass_act_nx   = 1'b0;
					res.pass_done = 1'b1;
				end else begin
					res.action      = owrs_pkg::ACT_CMD;
					res.command_out = item.command;
					bit_num_nx      = POS_W'(1);
					zero_pos_nx     = '0;
					pass_act_nx     = 1'b1;
				end
			end
			owrs_pkg::OP_PAIR: begin
				if (pass_act) begin
					if (item.id_bit && item.complement_bit) begin
						last_disc_nx  = '0;
						fam_disc_nx   = '0;
						last_dev_nx   = 1'b0;
						pass_act_nx   = 1'b0;
						res.pass_done = 1'b1;
					end else begin
						rom_nx        = rom_pair;
						zero_pos_nx   = lz_pair;
						fam_disc_nx   = fd_pair;
						bit_num_nx    = pos + POS_W'(1);
						res.action    = owrs_pkg::ACT_DIR;
						res.direction = dir;
						if (pos == POS_W'(ROM_BITS)) begin
							pass_act_nx   = 1'b0;
							res.pass_done = 1'b1;
							if (rom_pair[7:0] == 8'd0) begin
								last_disc_nx = '0;
								fam_disc_nx  = '0;
								last_dev_nx  = 1'b0;
							end else begin
								last_disc_nx = lz_pair;
								last_dev_nx  = (lz_pair == '0);
								res.found    = 1'b1;
							end
						end
					end
				end
			end
			owrs_pkg::OP_RESET: begin
				last_disc_nx = '0;
				fam_disc_nx  = '0;
				last_dev_nx  = 1'b0;
				pass_act_nx  = 1'b0;
			end
			owrs_pkg::OP_SKIP: begin
				last_disc_nx = POS_W'(fam_disc);
				fam_disc_nx  = '0;
				if (fam_disc == '0) begin
					last_dev_nx = 1'b1;
				end
				pass_act_nx = 1'b0;
			end
			owrs_pkg::OP_TARGET: begin
				rom_nx       = ROM_BITS'(target_family);
				last_disc_nx = POS_W'(ROM_BITS);
				fam_disc_nx  = '0;
				last_dev_nx  = 1'b0;
				pass_act_nx  = 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/one_wire_rom_search.sv */
// ---------------------------------------------------------------------------
// one_wire_rom_search
// one-wire rom search engine: direction choice and rom code tracking
// ---------------------------------------------------------------------------
// usage:
//   s_* carries one item per transfer: op in s_tuser, the bus read values
//   in s_tdata. m_* returns exactly one result per item, in order: the
//   action code in m_tuser, the command byte, direction, pass status, the
//   rom code and the last-device flag in m_tdata.
//   cfg_* writes target_family, taken by the target-family op; write it only
//   while no item is in flight.
// timing:
//   an accepted item is held in the input register and its result is shown
//   from the output register, so m_tvalid rises as the item moves from the
//   input register to the output register. one item per cycle is sustained
//   while m_tready stays high: the search state update is a single shallow
//   step between the two registers.
// reset and stall:
//   arst_n clears the search state, the target family and both valid flags.
//   while m_tready is low the result and the input register hold and
//   s_tready drops once the input register is full; nothing is lost.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module one_wire_rom_search #(
	parameter int ROM_BITS = owrs_pkg::ROM_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // no_presence, command[7:0], id_bit, complement_bit
	input  logic [2:0]  s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // command_out[7:0], direction, pass_done, found,
	                              // rom_out[63:0], last_device
	output logic [1:0]  m_tuser,  // action
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data  // target_family
);

	localparam int POS_W = $clog2(ROM_BITS+2);

	logic                          valid_s1;
	owrs_pkg::item_t               item_s1;
	logic                          valid_s2;
	owrs_pkg::result_t             res_s2;
	logic [owrs_pkg::CMD_W-1:0]    target_q;
	logic [ROM_BITS-1:0]           rom_q;
	logic [POS_W-1:0]              last_disc_q;
	logic [owrs_pkg::FD_W-1:0]     fam_disc_q;
	logic                          last_dev_q;
	logic [POS_W-1:0]              bit_num_q;
	logic [POS_W-1:0]              zero_pos_q;
	logic                          pass_q;

	logic [ROM_BITS-1:0]           rom_nx;
	logic [POS_W-1:0]              last_disc_nx;
	logic [owrs_pkg::FD_W-1:0]     fam_disc_nx;
	logic                          last_dev_nx;
	logic [POS_W-1:0]              bit_num_nx;
	logic [POS_W-1:0]              zero_pos_nx;
	logic                          pass_nx;
	owrs_pkg::result_t             res;
	logic                          advance;

	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	owrs_step #(
		.ROM_BITS(ROM_BITS)
	) u_step (
		.item         (item_s1),
		.target_family(target_q),
		.rom          (rom_q),
		.last_disc    (last_disc_q),
		.fam_disc     (fam_disc_q),
		.last_dev     (last_dev_q),
		.bit_num      (bit_num_q),
		.zero_pos     (zero_pos_q),
		.pass_act     (pass_q),
		.rom_nx       (rom_nx),
		.last_disc_nx (last_disc_nx),
		.fam_disc_nx  (fam_disc_nx),
		.last_dev_nx  (last_dev_nx),
		.bit_num_nx   (bit_num_nx),
		.zero_pos_nx  (zero_pos_nx),
		.pass_act_nx  (pass_nx),
		.res          (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op             <= owrs_pkg::op_t'(s_tuser);
			item_s1.no_presence    <= s_tdata[0];
			item_s1.command        <= s_tdata[8:1];
			item_s1.id_bit         <= s_tdata[9];
			item_s1.complement_bit <= s_tdata[10];
		end
	end

	// search state, updated as the item moves to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			rom_q       <= '0;
			last_disc_q <= '0;
			fam_disc_q  <= '0;
			last_dev_q  <= 1'b0;
			bit_num_q   <= POS_W'(1);
			zero_pos_q  <= '0;
			pass_q      <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				target_q <= cfg_data;
			end
			if (advance) begin
				rom_q       <= rom_nx;
				last_disc_q <= last_disc_nx;
				fam_disc_q  <= fam_disc_nx;
				last_dev_q  <= last_dev_nx;
				bit_num_q   <= bit_num_nx;
				zero_pos_q  <= zero_pos_nx;
				pass_q      <= pass_nx;
				valid_s2    <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	// rom and last-device come straight from state: it only moves with the result
	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.action;
	assign m_tdata  = {4'd0, last_dev_q, owrs_pkg::ROM_OUT_W'(rom_q), res_s2.found,
		res_s2.pass_done, res_s2.direction, res_s2.command_out};

	`ASSERT_SAME(a_found_has_family, m_tvalid && res_s2.found, rom_q[7:0] != 8'd0)
	`ASSERT_SAME(a_found_ends_dir, m_tvalid && res_s2.found,
		res_s2.pass_done && res_s2.action == owrs_pkg::ACT_DIR)
	`ASSERT_SAME(a_pass_bit_range, pass_q,
		bit_num_q >= POS_W'(1) && bit_num_q <= POS_W'(ROM_BITS))
	`ASSERT_SAME(a_last_dev_idle, last_dev_q, !pass_q)
	`ASSERT_NEXT(a_stall_holds_state, m_tvalid && !m_tready, $stable(rom_q))

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Checks the one-wire rom search engine against its own search predictor.
// A short table of directed items comes first. After it, simulated device
// populations on the bus are enumerated by full search passes, with family
// skips, target-family ops, bus glitches and stray items mixed in. The
// target family is rewritten between phases while the engine is idle.
// Every result is compared field by field, in order, with the expected one.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int          ROM_BITS   = owrs_pkg::ROM_BITS_DEF;
	localparam int          WD_LIMIT   = 1000;
	localparam int          HOLD_LEN   = 100;
	localparam int          CALM_AFTER = 1450;
	localparam logic [2:0]  OP_SPARE5  = 3'd5;
	localparam logic [2:0]  OP_SPARE7  = 3'd7;
	localparam int          MAX_DEVS   = 4;

	typedef struct packed {
		owrs_pkg::action_t action;
		logic [7:0]   cmd;
		logic         dir;
		logic         done;
		logic         found;
		logic [63:0]  rom;
		logic         last_dev;
	} srch_res_t;

	typedef struct packed {
		logic [2:0]   op;
		logic         nopres;
		logic [7:0]   cmd;
		logic         idb;
		logic         cmpb;
		logic         hand;
		srch_res_t    res;
	} vec_row_t;

	localparam srch_res_t NO_RES =
		'{owrs_pkg::ACT_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0};
	localparam srch_res_t MISS_0 =
		'{owrs_pkg::ACT_NONE, 8'h00, 1'b0, 1'b1, 1'b0, 64'h0, 1'b0};
	localparam srch_res_t MISS_FF =
		'{owrs_pkg::ACT_NONE, 8'h00, 1'b0, 1'b1, 1'b0, 64'hFF, 1'b0};

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [15:0]  s_tdata;   // no_presence, command[7:0], id_bit, complement_bit
	logic [2:0]   s_tuser;   // op
	logic         m_tvalid;
	logic         m_tready;
	logic [79:0]  m_tdata;   // command_out[7:0], direction, pass_done, found,
	                         // rom_out[63:0], last_device
	logic [1:0]   m_tuser;   // action
	logic         cfg_valid;
	logic         cfg_ready;
	logic [7:0]   cfg_data;  // target_family

	// predictor state
	logic [7:0]   tgt_family;
	logic [63:0]  rom_code;
	logic [6:0]   last_disc;
	logic [3:0]   fam_disc;
	logic         last_dev;
	logic [6:0]   bit_num;
	logic [6:0]   zero_pos;
	logic         in_pass;

	srch_res_t    result_q [$];
	int           n_sent;
	int           n_checked;
	int           n_err;
	int           n_found;
	int           n_miss;
	int           n_cfg;
	int           n_pops;
	int           idle_cyc;

	// simulated devices on the bus
	logic [63:0]  dev_rom [MAX_DEVS];
	int           n_devs;
	logic [MAX_DEVS-1:0] alive;

	// op, no_presence, command, id, complement, typed, expected
	vec_row_t dir_tab [24] = '{
		'{owrs_pkg::OP_PAIR,   1'b0, 8'h00, 1'b1, 1'b0, 1'b1, NO_RES},
		'{owrs_pkg::OP_START,  1'b1, 8'hFF, 1'b0, 1'b0, 1'b1, MISS_0},
		'{OP_SPARE7,           1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, NO_RES},
		'{owrs_pkg::OP_START,  1'b0, 8'hF0, 1'b0, 1'b0, 1'b1,
			'{owrs_pkg::ACT_CMD, 8'hF0, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0}},
		'{owrs_pkg::OP_PAIR,   1'b0, 8'h00, 1'b1, 1'b1, 1'b1, MISS_0},
		'{owrs_pkg::OP_PAIR,   1'b1, 8'hFF, 1'b1, 1'b0, 1'b1, NO_RES},
		'{owrs_pkg::OP_START,  1'b0, 8'h00, 1'b1, 1'b1, 1'b1,
			'{owrs_pkg::ACT_CMD, 8'h00, 1'b0, 1'b0, 1'b0, 64'h0, 1'b0}},
		'{owrs_pkg::OP_PAIR,   1'b0, 8'h00, 1'b1, 1'b0, 1'b1,
			'{owrs_pkg::ACT_DIR, 8'h00, 1'b1, 1'b0, 1'b0, 64'h1, 1'b0}},
		'{owrs_pkg::OP_PAIR,   1'b0, 8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
		'{owrs_pkg::OP_PAIR,   1'b0, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
		'{owrs_pkg::OP_START,  1'b0, 8'hEC, 1'b0, 1'b0, 1'b0, NO_RES},
		'{owrs_pkg::OP_PAIR,   1'b0, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
		'{owrs_pkg::OP_SKIP,   1'b0, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
		'{owrs_pkg::OP_START,  1'b0, 8'hF0, 1'b0, 1'b0, 1'b0, NO_RES},
		'{owrs_pkg::OP_PAIR,   1'b0, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
		'{owrs_pkg::OP_RESET,  1'b0, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
		'{owrs_pkg::OP_TARGET, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1,
			'{owrs_pkg::ACT_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 64'hFF, 1'b0}},
		'{owrs_pkg::OP_START,  1'b1, 8'hF0, 1'b0, 1'b0, 1'b1, MISS_FF},
		'{owrs_pkg::OP_SKIP,   1'b0, 8'h00, 1'b0, 1'b0, 1'b1,
			'{owrs_pkg::ACT_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 64'hFF, 1'b1}},
		'{owrs_pkg::OP_START,  1'b0, 8'hF0, 1'b0, 1'b0, 1'b1, MISS_FF},
		'{OP_SPARE5,           1'b1, 8'hA5, 1'b1, 1'b0, 1'b0, NO_RES},
		'{owrs_pkg::OP_TARGET, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
		'{owrs_pkg::OP_START,  1'b0, 8'h55, 1'b0, 1'b0, 1'b0, NO_RES},
		'{owrs_pkg::OP_PAIR,   1'b0, 8'h00, 1'b1, 1'b1, 1'b0, NO_RES}
	};

	one_wire_rom_search u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void forget_search();
		last_disc = '0;
		fam_disc  = '0;
		last_dev  = 1'b0;
	endfunction

	function automatic srch_res_t search_step(input logic [2:0] op, input logic nopres,
			input logic [7:0] cmd, input logic idb, input logic cmpb);
		srch_res_t r;
		logic [6:0] pos;
		r = NO_RES;
		case (op)
			owrs_pkg::OP_START: begin
				if (last_dev || nopres) begin
					forget_search();
					in_pass = 1'b0;
					r.done  = 1'b1;
				end else begin
					r.action  = owrs_pkg::ACT_CMD;
					r.cmd     = cmd;
					bit_num   = 7'd1;
					zero_pos  = '0;
					in_pass   = 1'b1;
				end
			end
			owrs_pkg::OP_PAIR: begin
				if (in_pass && idb && cmpb) begin
					forget_search();
					in_pass = 1'b0;
					r.done  = 1'b1;
				end else if (in_pass) begin
					pos = bit_num;
					if (pos < 1 || pos > ROM_BITS)
						pos = 7'd1;
					if (idb != cmpb) begin
						r.dir = idb;
					end else begin
						if (pos < last_disc)
							r.dir = rom_code[pos-1];
						else
							r.dir = (pos == last_disc);
						if (!r.dir) begin
							zero_pos = pos;
							if (pos < owrs_pkg::FAMILY_LIMIT)
								fam_disc = pos[3:0];
						end
					end
					rom_code[pos-1] = r.dir;
					r.action = owrs_pkg::ACT_DIR;
					bit_num  = pos + 7'd1;
					if (bit_num > ROM_BITS) begin
						in_pass   = 1'b0;
						r.done    = 1'b1;
						last_disc = zero_pos;
						if (last_disc == 0)
							last_dev = 1'b1;
						if (rom_code[7:0] == 0)
							forget_search();
						else
							r.found = 1'b1;
					end
				end
			end
			owrs_pkg::OP_RESET: begin
				forget_search();
				in_pass = 1'b0;
			end
			owrs_pkg::OP_SKIP: begin
				last_disc = {3'b000, fam_disc};
				fam_disc  = '0;
				if (last_disc == 0)
					last_dev = 1'b1;
				in_pass = 1'b0;
			end
			owrs_pkg::OP_TARGET: begin
				rom_code  = {56'h0, tgt_family};
				last_disc = 7'(ROM_BITS);
				fam_disc  = '0;
				last_dev  = 1'b0;
				in_pass   = 1'b0;
			end
			default: ;
		endcase
		r.rom      = rom_code;
		r.last_dev = last_dev;
		return r;
	endfunction

	// called at a rising edge, returns at the edge of the transfer
	task automatic send_item(input logic [2:0] op, input logic nopres, input logic [7:0] cmd,
			input logic idb, input logic cmpb, input logic hand, input srch_res_t hand_res,
			output srch_res_t got);
		int gap;
		gap = 0;
		if (n_sent < CALM_AFTER && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'b00000, cmpb, idb, cmd, nopres};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		got = search_step(op, nopres, cmd, idb, cmpb);
		result_q.push_back(hand ? hand_res : got);
		n_sent++;
		if (got.done && got.found)
			n_found++;
		else if (got.done)
			n_miss++;
	endtask

	task automatic send_noise();
		srch_res_t r;
		send_item(3'($urandom_range(owrs_pkg::OP_START, OP_SPARE7)), 1'($urandom),
			8'($urandom), 1'($urandom), 1'($urandom), 1'b0, NO_RES, r);
	endtask

	task automatic send_op(input logic [2:0] op);
		srch_res_t r;
		send_item(op, 1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 1'b0,
			NO_RES, r);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (result_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_family(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid  <= 1'b0;
		tgt_family  = v;
		n_cfg++;
	endtask

	task automatic new_population(input logic zero_fam);
		logic [63:0] base;
		int k;
		int j;
		n_devs = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, MAX_DEVS);
		base   = {$urandom, $urandom};
		if (zero_fam)
			base[7:0] = 8'h00;
		else if ($urandom_range(0, 2) == 0)
			base[7:0] = tgt_family;
		for (k = 0; k < MAX_DEVS; k++) begin
			dev_rom[k] = base;
			for (j = 0; j < $urandom_range(1, 3); j++)
				dev_rom[k][$urandom_range(8, 63)] ^= 1'b1;
			if (!zero_fam && $urandom_range(0, 2) == 0)
				dev_rom[k][$urandom_range(0, 7)] ^= 1'b1;
		end
		n_pops++;
	endtask

	// one search pass over the simulated devices, with the odd glitch or abort
	task automatic run_pass();
		srch_res_t r;
		logic idb;
		logic cmpb;
		logic [6:0] pos;
		int k;
		alive = '1;
		send_item(owrs_pkg::OP_START, (n_devs == 0) || ($urandom_range(0, 30) == 0),
			8'($urandom), 1'($urandom), 1'($urandom), 1'b0, NO_RES, r);
		while (in_pass) begin
			pos  = bit_num;
			idb  = 1'b1;
			cmpb = 1'b1;
			for (k = 0; k < n_devs; k++) begin
				if (alive[k]) begin
					idb  &= dev_rom[k][pos-1];
					cmpb &= ~dev_rom[k][pos-1];
				end
			end
			case ($urandom_range(0, 299))
				0: idb  = ~idb;
				1: cmpb = ~cmpb;
				2: begin
					send_noise();
					alive = '1;
				end
				default: ;
			endcase
			if (in_pass) begin
				send_item(owrs_pkg::OP_PAIR, 1'($urandom), 8'($urandom), idb, cmpb, 1'b0,
					NO_RES, r);
				for (k = 0; k < MAX_DEVS; k++)
					if (dev_rom[k][pos-1] != r.dir)
						alive[k] = 1'b0;
			end
		end
	endtask

	task automatic enumerate(input int stop_at, input logic zero_fam);
		int p;
		new_population(zero_fam);
		send_op(owrs_pkg::OP_RESET);
		for (p = 0; p < n_devs + 3 && n_sent < stop_at; p++) begin
			case ($urandom_range(0, 11))
				0: send_op(owrs_pkg::OP_SKIP);
				1: send_op(owrs_pkg::OP_TARGET);
				2: send_op(owrs_pkg::OP_RESET);
				3: send_noise();
				default: ;
			endcase
			run_pass();
			if (last_dev)
				break;
		end
	endtask

	// receiver: short random stalls, one long hold-off, calm at the end
	initial begin
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && n_checked >= 300) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				m_tready <= 1'b1;
			end else if (n_checked < CALM_AFTER && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result check and watchdog, sampled away from the driving edge
	always @(negedge clk) begin
		srch_res_t want;
		srch_res_t seen;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cyc = 0;
			else
				idle_cyc++;
			if (idle_cyc >= WD_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				seen = '{owrs_pkg::action_t'(m_tuser), m_tdata[7:0], m_tdata[8], m_tdata[9],
					m_tdata[10], m_tdata[74:11], m_tdata[75]};
				n_checked++;
				if (result_q.size() == 0) begin
					$error("result transfer with nothing expected");
					n_err++;
				end else begin
					want = result_q.pop_front();
					if (seen.action != want.action) begin
						$error("action: expected %0d, got %0d", want.action, seen.action);
						n_err++;
					end
					if (seen.cmd != want.cmd) begin
						$error("command_out: expected %0h, got %0h", want.cmd, seen.cmd);
						n_err++;
					end
					if (seen.dir != want.dir) begin
						$error("direction: expected %0d, got %0d", want.dir, seen.dir);
						n_err++;
					end
					if (seen.done != want.done) begin
						$error("pass_done: expected %0d, got %0d", want.done, seen.done);
						n_err++;
					end
					if (seen.found != want.found) begin
						$error("found: expected %0d, got %0d", want.found, seen.found);
						n_err++;
					end
					if (seen.rom != want.rom) begin
						$error("rom_out: expected %016h, got %016h", want.rom, seen.rom);
						n_err++;
					end
					if (seen.last_dev != want.last_dev) begin
						$error("last_device: expected %0d, got %0d", want.last_dev,
							seen.last_dev);
						n_err++;
					end
				end
			end
		end
	end

	initial begin
		srch_res_t r;
		logic [7:0] fam_set [4];
		int stop_at [4];
		int ph;
		int i;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = owrs_pkg::OP_START;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		tgt_family = '0;
		rom_code   = '0;
		forget_search();
		bit_num    = 7'd1;
		zero_pos   = '0;
		in_pass    = 1'b0;
		n_sent = 0; n_checked = 0; n_err = 0; n_found = 0; n_miss = 0;
		n_cfg = 0; n_pops = 0; idle_cyc = 0;
		fam_set = '{8'h00, 8'($urandom_range(1, 254)), 8'h28, 8'h80};
		stop_at = '{450, 900, 1300, 1700};

		@(posedge arst_n);
		@(posedge clk);
		write_family(8'hFF);
		for (i = 0; i < 24; i++)
			send_item(dir_tab[i].op, dir_tab[i].nopres, dir_tab[i].cmd, dir_tab[i].idb,
				dir_tab[i].cmpb, dir_tab[i].hand, dir_tab[i].res, r);

		for (ph = 0; ph < 4; ph++) begin
			wait_drained();
			write_family(fam_set[ph]);
			enumerate(stop_at[ph], ph == 0);
			while (n_sent < stop_at[ph])
				enumerate(stop_at[ph], $urandom_range(0, 4) == 0);
		end

		wait_drained();
		repeat (4) @(posedge clk);
		$display("covered %0d items in %0d device populations, %0d target family writes",
			n_sent, n_pops, n_cfg);
		$display("passes ended: %0d with a rom code found, %0d without", n_found, n_miss);
		if (n_err == 0 && result_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
